// ===== design/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 keystream cipher with IV.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W    = 8;
    localparam int SBOX_AW   = 8;
    localparam int SBOX_DEPTH = 1 << SBOX_AW;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 64;

    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [SBOX_AW-1:0]    t_sbox_addr;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_word;

    localparam t_cfg_idx CFG_KEY_LOW  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_KEY_HIGH = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_IV_LOW   = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_IV_HIGH  = t_cfg_idx'(3);

    // control group from the sequencer to the table
    typedef struct packed {
        logic       wr_en;
        t_sbox_addr wr_addr;
        t_byte      wr_data;
        t_sbox_addr rd_addr;
        logic       clear;
    } t_sbox_ctrl;

endpackage

// ===== design/rc4_iv_keystream_cipher.sv =====
// ----------------------------------------------------------------------------
// rc4_iv_keystream_cipher
// RC4 stream cipher keyed by a 16-byte IV followed by a 16-byte key.
// ----------------------------------------------------------------------------
// A taken byte passes states G_RI, G_RJ, G_WI, G_WJ, G_RK and G_OUT, which loads
// the output register once it is free; a start-of-message byte first runs the
// key schedule. No new byte is taken before the last one leaves G_OUT, as the single
// read and single write port of the permutation table are in use.
// Reset (synchronous, active low): indices zero, table reads as identity,
// key and IV registers zero, output empty.
// ----------------------------------------------------------------------------
module rc4_iv_keystream_cipher
    import rc4_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_byte     i_data_byte,
    input  logic      i_start_of_message,
    output logic      o_valid,
    input  logic      i_stall,
    output t_byte     o_result_byte,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  t_cfg_idx  i_cfg_index,
    input  t_cfg_word i_cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_K_RD  = 11'b000_0000_0010,
        ST_K_ACC = 11'b000_0000_0100,
        ST_K_WN  = 11'b000_0000_1000,
        ST_K_WA  = 11'b000_0001_0000,
        ST_G_RI  = 11'b000_0010_0000,
        ST_G_RJ  = 11'b000_0100_0000,
        ST_G_WI  = 11'b000_1000_0000,
        ST_G_WJ  = 11'b001_0000_0000,
        ST_G_RK  = 11'b010_0000_0000,
        ST_G_OUT = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    t_cfg_word  r_key_low, r_key_high, r_iv_low, r_iv_high;
    t_byte      r_i, n_i;
    t_byte      r_j, n_j;
    t_byte      r_n, n_n;
    t_byte      r_acc, n_acc;
    t_byte      r_si, n_si;
    t_byte      r_sj, n_sj;
    t_byte      r_data, n_data;
    logic       r_out_valid, n_out_valid;
    t_byte      r_out_data, n_out_data;
    t_sbox_ctrl sbox_ctrl;
    t_byte      rd_data;
    t_byte      sched_byte;
    t_byte      acc_sum;
    t_byte      j_sum;
    logic       out_free;

    function automatic t_byte byte_of(t_cfg_word lo, t_cfg_word hi, logic [3:0] n);
        t_cfg_word word;
        word = n[3] ? hi : lo;
        return word[{n[2:0], 3'b000} +: BYTE_W];
    endfunction

    rc4_sbox u_sbox (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (sbox_ctrl),
        .o_rd_data (rd_data)
    );

    // first 16 schedule bytes come from the iv, the rest cycle through the key
    assign sched_byte = (r_n[7:4] == 4'd0) ? byte_of(r_iv_low, r_iv_high, r_n[3:0])
                                           : byte_of(r_key_low, r_key_high, r_n[3:0]);
    assign acc_sum  = r_acc + rd_data + sched_byte;
    assign j_sum    = r_j + rd_data;
    assign out_free = !r_out_valid || !i_stall;

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_result_byte = r_out_data;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_acc       = r_acc;
        n_si        = r_si;
        n_sj        = r_sj;
        n_data      = r_data;
        n_out_valid = r_out_valid && i_stall;
        n_out_data  = r_out_data;
        sbox_ctrl.wr_en   = 1'b0;
        sbox_ctrl.wr_addr = r_i;
        sbox_ctrl.wr_data = rd_data;
        sbox_ctrl.rd_addr = r_si + r_sj;
        sbox_ctrl.clear   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_data = i_data_byte;
                    if (i_start_of_message) begin
                        n_i             = '0;
                        n_j             = '0;
                        n_n             = '0;
                        n_acc           = '0;
                        sbox_ctrl.clear = 1'b1;
                        n_state         = ST_K_RD;
                    end else begin
                        n_state = ST_G_RI;
                    end
                end
            end
            ST_K_RD: begin
                sbox_ctrl.rd_addr = r_n;
                n_state           = ST_K_ACC;
            end
            ST_K_ACC: begin
                n_si              = rd_data;
                n_acc             = acc_sum;
                sbox_ctrl.rd_addr = acc_sum;
                n_state           = ST_K_WN;
            end
            ST_K_WN: begin
                sbox_ctrl.wr_en   = 1'b1;
                sbox_ctrl.wr_addr = r_n;
                sbox_ctrl.wr_data = rd_data;
                n_state           = ST_K_WA;
            end
            ST_K_WA: begin
                sbox_ctrl.wr_en   = 1'b1;
                sbox_ctrl.wr_addr = r_acc;
                sbox_ctrl.wr_data = r_si;
                n_n               = r_n + 1'b1;
                n_state           = (r_n == '1) ? ST_G_RI : ST_K_RD;
            end
            ST_G_RI: begin
                n_i               = r_i + 1'b1;
                sbox_ctrl.rd_addr = r_i + 1'b1;
                n_state           = ST_G_RJ;
            end
            ST_G_RJ: begin
                n_si              = rd_data;
                n_j               = j_sum;
                sbox_ctrl.rd_addr = j_sum;
                n_state           = ST_G_WI;
            end
            ST_G_WI: begin
                n_sj              = rd_data;
                sbox_ctrl.wr_en   = 1'b1;
                sbox_ctrl.wr_addr = r_i;
                sbox_ctrl.wr_data = rd_data;
                n_state           = ST_G_WJ;
            end
            ST_G_WJ: begin
                sbox_ctrl.wr_en   = 1'b1;
                sbox_ctrl.wr_addr = r_j;
                sbox_ctrl.wr_data = r_si;
                n_state           = ST_G_RK;
            end
            ST_G_RK: begin
                n_state = ST_G_OUT;
            end
            ST_G_OUT: begin
                // keystream read address is held here, so the data stays put
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data ^ rd_data;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_iv_low    <= '0;
            r_iv_high   <= '0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_n         <= n_n;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                    CFG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_data     <= n_data;
        r_out_data <= n_out_data;
    end

endmodule

// ===== design/rc4_sbox.sv =====
// ----------------------------------------------------------------------------
// rc4_sbox
// 256 x 8 permutation table, one write and one registered read per cycle.
// Per-entry valid bits make an unwritten entry read as its own index.
// ----------------------------------------------------------------------------
module rc4_sbox
    import rc4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sbox_ctrl i_ctrl,
    output t_byte      o_rd_data
);

    t_byte                 r_mem [SBOX_DEPTH];
    logic [SBOX_DEPTH-1:0] r_valid;
    t_byte                 r_rd_data;
    logic                  r_rd_valid;
    t_sbox_addr            r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= i_ctrl.wr_data;
        end
        r_rd_data <= r_mem[i_ctrl.rd_addr];
        r_rd_addr <= i_ctrl.rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_valid <= '0;
            end else if (i_ctrl.wr_en) begin
                r_valid[i_ctrl.wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_ctrl.rd_addr] && !i_ctrl.clear;
        end
    end

    // identity value for entries not yet written since the last clear
    assign o_rd_data = r_rd_valid ? r_rd_data : t_byte'(r_rd_addr);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RC4 keystream cipher with IV. A directed table
// covers the reset state, key schedule restarts, mid-message register writes
// and ignored register indexes. Random phases follow with new key/IV
// settings and messages of random bytes. Every result word is checked against
// a local RC4 predictor, or a fixed value for the first directed bytes. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import rc4_pkg::*;

    localparam int QUIET_LIMIT     = 5000;
    localparam int PRESSURE_CYCLES = 600;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PHASES          = 12;
    localparam int PHASE_WORDS     = 110;

    localparam t_cfg_idx CFG_IDX_SPARE = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_IDX_TOP   = t_cfg_idx'(255);

    typedef struct {
        bit        is_reg;
        t_cfg_idx  idx;
        t_cfg_word val;
        t_byte     data;
        bit        som;
        bit        known;
        t_byte     known_val;
    } t_plan_row;

    typedef struct {
        t_cfg_idx  idx;
        t_cfg_word val;
    } t_reg_write;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_byte     i_data_byte;
    logic      i_start_of_message;
    logic      o_valid;
    logic      i_stall;
    t_byte     o_result_byte;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index;
    t_cfg_word i_cfg_data;

    // predictor state
    t_byte     sbox [256];
    t_byte     ks_i;
    t_byte     ks_j;
    t_cfg_word key_lo;
    t_cfg_word key_hi;
    t_cfg_word iv_lo;
    t_cfg_word iv_hi;

    t_byte      pending_cipher [$];
    t_plan_row  plan [$];
    t_reg_write pending_writes [$];
    t_cfg_idx   reg_ids [4];

    int        errors;
    int        results_seen;
    int        quiet_cycles;
    bit        send_burst;
    bit        take_burst;
    t_byte     want_byte;

    always #2 i_clk = ~i_clk;

    rc4_iv_keystream_cipher uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_start_of_message (i_start_of_message),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_byte      (o_result_byte),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // schedule key: iv bytes first, then the key repeated
    function automatic t_byte sched_byte(int n);
        t_cfg_word w;
        if (n < 16) begin
            w = n[3] ? iv_hi : iv_lo;
        end else begin
            w = n[3] ? key_hi : key_lo;
        end
        return w[(n % 8) * 8 +: 8];
    endfunction

    function automatic void rekey();
        t_byte acc;
        t_byte tmp;
        for (int n = 0; n < 256; n++) sbox[n] = t_byte'(n);
        acc = '0;
        for (int n = 0; n < 256; n++) begin
            acc = acc + sbox[n] + sched_byte(n);
            tmp = sbox[n];
            sbox[n] = sbox[acc];
            sbox[acc] = tmp;
        end
    endfunction

    function automatic t_byte cipher_byte(t_byte d, bit som);
        t_byte tmp;
        if (som) begin
            ks_i = '0;
            ks_j = '0;
            rekey();
        end
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + sbox[ks_i];
        tmp = sbox[ks_i];
        sbox[ks_i] = sbox[ks_j];
        sbox[ks_j] = tmp;
        return d ^ sbox[t_byte'(sbox[ks_i] + sbox[ks_j])];
    endfunction

    function automatic void store_reg(t_cfg_idx idx, t_cfg_word val);
        case (idx)
            CFG_KEY_LOW:  key_lo = val;
            CFG_KEY_HIGH: key_hi = val;
            CFG_IV_LOW:   iv_lo = val;
            CFG_IV_HIGH:  iv_hi = val;
            default: ;
        endcase
    endfunction

    function automatic t_cfg_word pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic plan_byte(t_byte d, bit som, bit known, t_byte known_val);
        t_plan_row row;
        row.is_reg    = 1'b0;
        row.idx       = CFG_KEY_LOW;
        row.val       = '0;
        row.data      = d;
        row.som       = som;
        row.known     = known;
        row.known_val = known_val;
        plan.push_back(row);
    endtask

    task automatic plan_reg(t_cfg_idx idx, t_cfg_word val);
        t_plan_row row;
        row.is_reg    = 1'b1;
        row.idx       = idx;
        row.val       = val;
        row.data      = '0;
        row.som       = 1'b0;
        row.known     = 1'b0;
        row.known_val = '0;
        plan.push_back(row);
    endtask

    task automatic queue_write(t_cfg_idx idx, t_cfg_word val);
        t_reg_write w;
        w.idx = idx;
        w.val = val;
        pending_writes.push_back(w);
    endtask

    // back-to-back register writes, valid dropped after the last one
    task automatic apply_reg_writes();
        t_reg_write w;
        if (pending_writes.size() != 0) begin
            while (pending_writes.size() != 0) begin
                w = pending_writes.pop_front();
                i_cfg_valid <= 1'b1;
                i_cfg_index <= w.idx;
                i_cfg_data  <= w.val;
                do @(posedge i_clk); while (!o_cfg_ready);
                store_reg(w.idx, w.val);
            end
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic drain_outputs();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cipher.size() != 0);
    endtask

    task automatic feed_byte(t_byte d, bit som, bit known, t_byte known_val);
        int unsigned gap;
        t_byte       predicted;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_data_byte        <= d;
        i_start_of_message <= som;
        do @(posedge i_clk); while (o_stall);
        predicted = cipher_byte(d, som);
        pending_cipher.push_back(known ? known_val : predicted);
    endtask

    initial begin : stimulus
        bit som;
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_data_byte        <= '0;
        i_start_of_message <= 1'b0;
        i_cfg_valid        <= 1'b0;
        i_cfg_index        <= CFG_KEY_LOW;
        i_cfg_data         <= '0;
        errors       = 0;
        results_seen = 0;
        send_burst   = 1'b0;
        key_lo = '0;
        key_hi = '0;
        iv_lo  = '0;
        iv_hi  = '0;
        ks_i   = '0;
        ks_j   = '0;
        for (int n = 0; n < 256; n++) sbox[n] = t_byte'(n);
        reg_ids[0] = CFG_KEY_LOW;
        reg_ids[1] = CFG_KEY_HIGH;
        reg_ids[2] = CFG_IV_LOW;
        reg_ids[3] = CFG_IV_HIGH;

        // no start yet: generator runs on the identity table
        plan_byte(8'h00, 1'b0, 1'b1, 8'h02);
        plan_byte(8'hFF, 1'b0, 1'b1, 8'hFA);
        plan_byte(8'h80, 1'b0, 1'b1, 8'h87);
        plan_byte(8'h55, 1'b1, 1'b0, '0);
        plan_byte(8'hAA, 1'b0, 1'b0, '0);
        plan_byte(8'h0F, 1'b0, 1'b0, '0);
        plan_reg(CFG_KEY_LOW, '1);
        plan_reg(CFG_KEY_HIGH, '1);
        plan_reg(CFG_IV_LOW, '1);
        plan_reg(CFG_IV_HIGH, '1);
        plan_reg(CFG_IDX_SPARE, 64'h0123_4567_89AB_CDEF);
        plan_reg(CFG_IDX_TOP, '0);
        // mid-message write: old schedule stays until the next start
        plan_byte(8'h01, 1'b0, 1'b0, '0);
        plan_byte(8'hF0, 1'b1, 1'b0, '0);
        plan_byte(8'hFF, 1'b1, 1'b0, '0);
        plan_byte(8'h7F, 1'b0, 1'b0, '0);
        plan_byte(8'h00, 1'b0, 1'b0, '0);
        plan_reg(CFG_KEY_LOW, 64'h0706_0504_0302_0100);
        plan_reg(CFG_KEY_HIGH, 64'h0F0E_0D0C_0B0A_0908);
        plan_reg(CFG_IV_LOW, 64'h8877_6655_4433_2211);
        plan_reg(CFG_IV_HIGH, 64'hFFEE_DDCC_BBAA_9900);
        plan_byte(8'hC3, 1'b1, 1'b0, '0);
        plan_byte(8'h3C, 1'b0, 1'b0, '0);
        plan_byte(8'hFF, 1'b0, 1'b0, '0);
        plan_byte(8'h00, 1'b0, 1'b0, '0);
        plan_reg(CFG_KEY_LOW, '0);
        plan_reg(CFG_KEY_HIGH, '1);
        plan_reg(CFG_IV_LOW, '1);
        plan_reg(CFG_IV_HIGH, '0);
        plan_byte(8'h5A, 1'b1, 1'b0, '0);
        plan_byte(8'hA5, 1'b0, 1'b0, '0);
        plan_byte(8'h12, 1'b0, 1'b0, '0);
        plan_reg(CFG_KEY_LOW, '0);
        plan_reg(CFG_KEY_HIGH, '0);
        plan_reg(CFG_IV_LOW, '0);
        plan_reg(CFG_IV_HIGH, '0);
        plan_byte(8'h00, 1'b1, 1'b0, '0);
        plan_byte(8'hFF, 1'b0, 1'b0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < plan.size(); r++) begin
            if (plan[r].is_reg) begin
                if (r == 0 || !plan[r-1].is_reg) drain_outputs();
                queue_write(plan[r].idx, plan[r].val);
                if (r + 1 == plan.size() || !plan[r+1].is_reg) apply_reg_writes();
            end else begin
                feed_byte(plan[r].data, plan[r].som, plan[r].known, plan[r].known_val);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_outputs();
            for (int k = 0; k < 4; k++) begin
                if (p == 0 || $urandom_range(0, 2) == 0) queue_write(reg_ids[k], pick_word());
            end
            if ($urandom_range(0, 3) == 0) begin
                queue_write(t_cfg_idx'($urandom_range(4, 255)), pick_word());
            end
            apply_reg_writes();
            // mostly whole messages: a start word followed by payload words
            for (int k = 0; k < PHASE_WORDS; k++) begin
                som = (k == 0 && $urandom_range(0, 7) != 0) || $urandom_range(0, 39) == 0;
                feed_byte(t_byte'($urandom_range(0, 255)), som, 1'b0, '0);
            end
        end

        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned hold;
        bit          held_off;
        i_stall <= 1'b1;
        held_off   = 1'b0;
        take_burst = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
            hold = take_burst ? 0 : $urandom_range(0, 10);
            // one long hold-off so the block backs up into its input
            if (!held_off && results_seen >= 150) begin
                hold = PRESSURE_CYCLES;
                held_off = 1'b1;
            end
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_cipher.size() == 0) begin
                $error("result_byte with no word pending: actual %02h", o_result_byte);
                errors++;
            end else begin
                want_byte = pending_cipher.pop_front();
                if (o_result_byte !== want_byte) begin
                    $error("result_byte mismatch: expected %02h, actual %02h",
                           want_byte, o_result_byte);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
